FILE: rtl/c3k_pkg.sv
// c3k_pkg: shared constants, types and kernel arithmetic for the 3x3 RGB filter.
// Used by the interfaces and by every c3k module; depends on nothing.
package c3k_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WCFG_W     = COL_W + 1;
  localparam int HCFG_W     = ROW_W + 1;
  localparam int PIX_W      = 24;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HCFG_W;
  localparam int SUM_W      = 13;

  localparam logic [WCFG_W-1:0] MAX_W_CFG = WCFG_W'(MAX_WIDTH);
  localparam logic [HCFG_W-1:0] MAX_H_CFG = HCFG_W'(MAX_HEIGHT);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [2:0]        KERNEL_RST = 3'd0;
  localparam logic [WCFG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [HCFG_W-1:0] HEIGHT_RST = 13'd768;

  // kernel codes
  localparam logic [2:0] KERN_GAUSS   = 3'd0;
  localparam logic [2:0] KERN_OUTLINE = 3'd1;
  localparam logic [2:0] KERN_EMBOSS  = 3'd2;
  localparam logic [2:0] KERN_SHARPEN = 3'd3;
  localparam logic [2:0] KERN_BOX     = 3'd4;

  // ceil(2^16 / 9), exact for sums up to 9 * 255
  localparam logic [12:0] BOX_RECIP = 13'd7282;

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [8:0][PIX_W-1:0]   pix_win_t;
  typedef logic [8:0][7:0]         chan9_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic             res0;
    logic             border;
    logic             res1;
    logic             res2;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } item_ctl_t;

  typedef struct packed {
    logic [2:0]       mask;
    pix_t             rgb0;
    pix_t             mid;
    pix_t             pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_bundle_t;

  function automatic sum_t kern_sum(input logic [2:0] k, input chan9_t p);
    sum_t s [9];
    sum_t res;
    for (int i = 0; i < 9; i++) begin
      s[i] = sum_t'({5'b0, p[i]});
    end
    case (k)
      KERN_GAUSS: begin
        res = (s[0] + s[2] + s[6] + s[8]) + ((s[1] + s[3] + s[5] + s[7]) <<< 1)
              + (s[4] <<< 2);
      end
      KERN_OUTLINE: begin
        res = (s[4] <<< 3) - (s[0] + s[1] + s[2] + s[3] + s[5] + s[6] + s[7] + s[8]);
      end
      KERN_EMBOSS: begin
        res = (s[4] + s[5] + s[7] + (s[8] <<< 1)) - ((s[0] <<< 1) + s[1] + s[3]);
      end
      KERN_SHARPEN: begin
        res = ((s[4] <<< 2) + s[4]) - (s[1] + s[3] + s[5] + s[7]);
      end
      KERN_BOX: begin
        res = s[0] + s[1] + s[2] + s[3] + s[4] + s[5] + s[6] + s[7] + s[8];
      end
      default: begin
        res = s[4];
      end
    endcase
    return res;
  endfunction

  function automatic logic [7:0] kern_norm(input logic [2:0] k, input sum_t s);
    logic [24:0] prod;
    logic [7:0]  res;
    prod = {13'b0, s[11:0]} * {12'b0, BOX_RECIP};
    if (s < 0) begin
      res = 8'd0;
    end else begin
      case (k)
        KERN_GAUSS: res = s[11:4];
        KERN_BOX:   res = prod[23:16];
        default:    res = (s > 13'sd255) ? 8'd255 : s[7:0];
      endcase
    end
    return res;
  endfunction

endpackage

FILE: rtl/c3k_ifs.sv
// c3k_ifs: valid/ready channel interfaces of the 3x3 RGB filter
// (pixel input, result output, register write). Depends on c3k_pkg.
interface c3k_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                output ready);
endinterface

interface c3k_res_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_red;
  logic [7:0]                  out_green;
  logic [7:0]                  out_blue;
  logic [c3k_pkg::COL_W-1:0]   out_col;
  logic [c3k_pkg::ROW_W-1:0]   out_row;
  logic                        frame_last;
  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_col, output out_row, output frame_last, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_col, input out_row, input frame_last, output ready);
endinterface

interface c3k_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [c3k_pkg::CFG_IDX_W-1:0]    addr;
  logic [c3k_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/c3k_line_mem.sv
// c3k_line_mem: the two line stores as one memory, upper and middle row per column,
// with a zero-fill sweep after reset and write-through on a same-address read.
// Depends on c3k_pkg.
module c3k_line_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [c3k_pkg::COL_W-1:0]   rd_addr,
  output logic [c3k_pkg::LINE_W-1:0]  rd_data,
  input  logic                        wr_en,
  input  logic [c3k_pkg::COL_W-1:0]   wr_addr,
  input  logic [c3k_pkg::LINE_W-1:0]  wr_data,
  output logic                        clearing
);

  logic [c3k_pkg::LINE_W-1:0] mem [c3k_pkg::MAX_WIDTH];
  logic [c3k_pkg::LINE_W-1:0] rd_data_r;
  logic                       clr_r;
  logic [c3k_pkg::COL_W-1:0]  clr_cnt_r;

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == c3k_pkg::COL_W'(c3k_pkg::MAX_WIDTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a read of the column being written this cycle sees the new entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: rtl/c3k_filter.sv
// c3k_filter: per-channel 3x3 weighted sums registered from the window,
// then clamping and the exact /16 or /9 scaling. Depends on c3k_pkg.
module c3k_filter (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0]          kernel,
  input  c3k_pkg::pix_win_t   win,
  output c3k_pkg::pix_t       rgb
);

  c3k_pkg::chan9_t ch_px [3];
  c3k_pkg::sum_t   sum_r [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        ch_px[ch][i] = win[i][(2 - ch) * 8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_r[ch] <= c3k_pkg::kern_sum(kernel, ch_px[ch]);
      end
    end
  end

  assign rgb = {c3k_pkg::kern_norm(kernel, sum_r[0]),
                c3k_pkg::kern_norm(kernel, sum_r[1]),
                c3k_pkg::kern_norm(kernel, sum_r[2])};

endmodule

FILE: rtl/c3k_emitter.sv
// c3k_emitter: result register holding up to three results of one item and
// handing them out one per handshake. Depends on c3k_pkg and c3k_res_if.
module c3k_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  c3k_pkg::res_bundle_t  bundle,
  output logic                  free,
  c3k_res_if.source             out_res
);

  logic [2:0]           mask_r;
  c3k_pkg::res_bundle_t data_r;
  logic                 single;
  logic                 out_fire;
  c3k_pkg::pix_t        sel_rgb;

  assign single   = (mask_r & (mask_r - 3'd1)) == 3'd0;
  assign out_fire = out_res.valid && out_res.ready;
  // takes the next item once at most one result is left and it goes this cycle
  assign free     = (mask_r == 3'd0) || (single && out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 3'd0;
    end else if (free) begin
      mask_r <= bundle.mask;
    end else if (out_fire) begin
      mask_r <= mask_r & (mask_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      data_r <= bundle;
    end
  end

  always_comb begin
    out_res.valid      = mask_r != 3'd0;
    out_res.frame_last = 1'b0;
    if (mask_r[0]) begin
      sel_rgb         = data_r.rgb0;
      out_res.out_col = data_r.col - 1'b1;
      out_res.out_row = data_r.row - 1'b1;
    end else if (mask_r[1]) begin
      sel_rgb         = data_r.mid;
      out_res.out_col = data_r.col;
      out_res.out_row = data_r.row - 1'b1;
    end else begin
      sel_rgb            = data_r.pix;
      out_res.out_col    = data_r.col;
      out_res.out_row    = data_r.row;
      out_res.frame_last = data_r.last;
    end
    out_res.out_red   = sel_rgb[23:16];
    out_res.out_green = sel_rgb[15:8];
    out_res.out_blue  = sel_rgb[7:0];
  end

endmodule

FILE: rtl/conv3x3_kernel_filter.sv
// conv3x3_kernel_filter: top level of the 3x3 RGB convolution filter.
// Depends on c3k_pkg, c3k_ifs, c3k_line_mem, c3k_filter and c3k_emitter.

// Takes one RGB pixel per clock in row order, while the output is not stalled,
// and returns filtered pixels tagged with column and row, one row and one column
// behind the input. The path is an input stage with the line-store read, the 3x3
// window, a registered sum stage and a result register. The line-store memory has
// one read and one write port, which sets the rate at one pixel per clock; in the
// last row of a frame one pixel can give up to three results, and the input then
// waits while the extra results are handed out. After reset the line stores are
// zero-filled, and no pixel is taken meanwhile; register writes are taken at any
// time and should only be issued while the block is idle.
module conv3x3_kernel_filter (
  input  logic        clk,
  input  logic        rst_n,
  c3k_cfg_if.sink     cfg_wr,
  c3k_pix_if.sink     in_pix,
  c3k_res_if.source   out_res
);

  // configuration registers
  logic [2:0]                  kern_r;
  logic [c3k_pkg::WCFG_W-1:0]  fw_r;
  logic [c3k_pkg::HCFG_W-1:0]  fh_r;
  logic [c3k_pkg::WCFG_W-1:0]  w_eff;
  logic [c3k_pkg::HCFG_W-1:0]  h_eff;

  // position counters
  logic [c3k_pkg::COL_W-1:0]   col_cnt_r, col_cnt_nxt;
  logic [c3k_pkg::ROW_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic                        col_wrap;
  logic [c3k_pkg::HCFG_W-1:0]  row_pre;
  logic [c3k_pkg::COL_W-1:0]   cur_c;
  logic [c3k_pkg::ROW_W-1:0]   cur_r;
  c3k_pkg::item_ctl_t          cur_ctl;

  // pipeline
  logic                        in_fire;
  logic                        adv;
  logic                        clearing;
  logic                        a_v_r, s1_v_r, s2_v_r;
  c3k_pkg::item_ctl_t          a_ctl_r, s1_ctl_r, s2_ctl_r;
  c3k_pkg::pix_t               a_pix_r;
  c3k_pkg::pix_win_t           win_r;
  c3k_pkg::pix_t               s2_win4_r, s2_win5_r, s2_pix_r;
  logic [c3k_pkg::LINE_W-1:0]  line_rd;
  c3k_pkg::pix_t               filt_rgb;
  c3k_pkg::res_bundle_t        bundle;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r <= c3k_pkg::KERNEL_RST;
      fw_r   <= c3k_pkg::WIDTH_RST;
      fh_r   <= c3k_pkg::HEIGHT_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.addr)
        c3k_pkg::CFG_KERNEL: kern_r <= cfg_wr.data[2:0];
        c3k_pkg::CFG_WIDTH:  fw_r   <= cfg_wr.data[c3k_pkg::WCFG_W-1:0];
        c3k_pkg::CFG_HEIGHT: fh_r   <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_r == '0) begin
      w_eff = c3k_pkg::WCFG_W'(1);
    end else if (fw_r > c3k_pkg::MAX_W_CFG) begin
      w_eff = c3k_pkg::MAX_W_CFG;
    end else begin
      w_eff = fw_r;
    end
    if (fh_r == '0) begin
      h_eff = c3k_pkg::HCFG_W'(1);
    end else if (fh_r > c3k_pkg::MAX_H_CFG) begin
      h_eff = c3k_pkg::MAX_H_CFG;
    end else begin
      h_eff = fh_r;
    end
  end

  // position of the incoming item; a count left out of range by a size change restarts
  always_comb begin
    col_wrap = {1'b0, col_cnt_r} >= w_eff;
    cur_c    = col_wrap ? '0 : col_cnt_r;
    row_pre  = {1'b0, row_cnt_r} + c3k_pkg::HCFG_W'(col_wrap);
    cur_r    = (row_pre >= h_eff) ? '0 : row_pre[c3k_pkg::ROW_W-1:0];

    cur_ctl.col    = cur_c;
    cur_ctl.row    = cur_r;
    cur_ctl.last   = {1'b0, cur_c} == (w_eff - 1'b1);
    cur_ctl.res0   = (cur_r != '0) && (cur_c != '0);
    cur_ctl.border = (cur_r == c3k_pkg::ROW_W'(1)) || (cur_c == c3k_pkg::COL_W'(1));
    cur_ctl.res1   = (cur_r != '0) && cur_ctl.last;
    cur_ctl.res2   = {1'b0, cur_r} == (h_eff - 1'b1);

    if (cur_ctl.last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = cur_ctl.res2 ? '0 : cur_r + 1'b1;
    end else begin
      col_cnt_nxt = cur_c + 1'b1;
      row_cnt_nxt = cur_r;
    end
  end

  assign in_pix.ready = !clearing && (!a_v_r || adv);
  assign in_fire      = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      a_v_r     <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
      a_v_r <= in_fire || (a_v_r && !adv);
      if (adv) begin
        s1_v_r <= a_v_r;
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_ctl_r <= cur_ctl;
      a_pix_r <= {in_pix.in_red, in_pix.in_green, in_pix.in_blue};
    end
    if (adv) begin
      s1_ctl_r  <= a_ctl_r;
      s2_ctl_r  <= s1_ctl_r;
      s2_win4_r <= win_r[4];
      s2_win5_r <= win_r[5];
      s2_pix_r  <= win_r[8];
    end
  end

  // window shifts one column as the item leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv && a_v_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= line_rd[c3k_pkg::LINE_W-1:c3k_pkg::PIX_W];
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= line_rd[c3k_pkg::PIX_W-1:0];
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= a_pix_r;
    end
  end

  c3k_line_mem u_line_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (cur_c),
    .rd_data  (line_rd),
    .wr_en    (adv && a_v_r),
    .wr_addr  (a_ctl_r.col),
    .wr_data  ({line_rd[c3k_pkg::PIX_W-1:0], a_pix_r}),
    .clearing (clearing)
  );

  c3k_filter u_filter (
    .clk    (clk),
    .en     (adv),
    .kernel (kern_r),
    .win    (win_r),
    .rgb    (filt_rgb)
  );

  always_comb begin
    bundle.mask = s2_v_r ? {s2_ctl_r.res2, s2_ctl_r.res1, s2_ctl_r.res0} : 3'd0;
    bundle.rgb0 = s2_ctl_r.border ? s2_win4_r : filt_rgb;
    bundle.mid  = s2_win5_r;
    bundle.pix  = s2_pix_r;
    bundle.col  = s2_ctl_r.col;
    bundle.row  = s2_ctl_r.row;
    bundle.last = s2_ctl_r.last;
  end

  c3k_emitter u_emitter (
    .clk     (clk),
    .rst_n   (rst_n),
    .bundle  (bundle),
    .free    (adv),
    .out_res (out_res)
  );

endmodule

FILE: tb/conv3x3_kernel_filter_tb.sv
`timescale 1ns / 1ps
// conv3x3_kernel_filter_tb: self-checking bench for the 3x3 RGB convolution filter.
// Drives pixel frames and register writes, predicts every result pixel with its own
// line-store copy and compares each output field. Depends on c3k_pkg and c3k_ifs.
module conv3x3_kernel_filter_tb;
  import c3k_pkg::*;

  localparam logic [2:0] KERN_UNKNOWN = 3'd7;
  localparam int RANDOM_ITEMS = 240;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } px_result_t;

  logic clk = 1'b0;
  logic rst_n;

  c3k_cfg_if cfg_bus ();
  c3k_pix_if pix_bus ();
  c3k_res_if res_bus ();

  conv3x3_kernel_filter DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_bus),
    .in_pix  (pix_bus),
    .out_res (res_bus)
  );

  always #4 clk = ~clk;

  // filter state as the block should hold it
  pix_t             line_top [MAX_WIDTH];
  pix_t             line_mid [MAX_WIDTH];
  pix_t             win [9];
  int unsigned      next_col;
  int unsigned      next_row;
  logic [2:0]       sel_kernel;
  logic [WCFG_W-1:0] cfg_width;
  logic [HCFG_W-1:0] cfg_height;

  px_result_t expected_px [$];
  int fail_count = 0;
  int pixels_sent = 0;
  int burst_left = 0;

  // output stall pattern, reloaded each time the phase counter wraps
  logic [31:0] rx_mask = '1;
  logic [4:0]  rx_phase = '0;

  assign res_bus.ready = rx_mask[rx_phase];

  always @(negedge clk) begin
    rx_phase <= rx_phase + 5'd1;
    if (rx_phase == 5'd31) begin
      case ($urandom_range(0, 3))
        0: rx_mask <= '1;
        1: rx_mask <= $urandom;
        2: rx_mask <= $urandom | $urandom;
        default: rx_mask <= $urandom & $urandom;
      endcase
    end
  end

  function automatic void reset_filter_state();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_top[i] = '0;
      line_mid[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    next_col = 0;
    next_row = 0;
    sel_kernel = KERNEL_RST;
    cfg_width = WIDTH_RST;
    cfg_height = HEIGHT_RST;
  endfunction

  function automatic logic [7:0] conv_channel(input int sh);
    int p [9];
    int acc;
    for (int i = 0; i < 9; i++) p[i] = int'(win[i][sh +: 8]);
    case (sel_kernel)
      KERN_GAUSS:
        acc = (p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] + 2 * p[5] + p[6]
               + 2 * p[7] + p[8]) / 16;
      KERN_OUTLINE:
        acc = 8 * p[4] - (p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8]);
      KERN_EMBOSS:
        acc = p[4] + p[5] + p[7] + 2 * p[8] - 2 * p[0] - p[1] - p[3];
      KERN_SHARPEN:
        acc = 5 * p[4] - p[1] - p[3] - p[5] - p[7];
      KERN_BOX:
        acc = (p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8]) / 9;
      default:
        acc = p[4];
    endcase
    if (acc < 0) return 8'd0;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  function automatic void expect_px(input pix_t px, input int unsigned col,
                                    input int unsigned row, input logic last);
    px_result_t e;
    e.red = px[23:16];
    e.green = px[15:8];
    e.blue = px[7:0];
    e.col = COL_W'(col);
    e.row = ROW_W'(row);
    e.last = last;
    expected_px.push_back(e);
  endfunction

  // one accepted pixel: shift the window, update line stores, queue its results
  function automatic void track_pixel(input pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    pix_t filt;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
    // size may have shrunk under the current position
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    c = next_col;
    r = next_row;
    for (int j = 0; j < 3; j++) begin
      win[j * 3] = win[j * 3 + 1];
      win[j * 3 + 1] = win[j * 3 + 2];
    end
    win[2] = line_top[c];
    win[5] = line_mid[c];
    win[8] = px;
    line_top[c] = line_mid[c];
    line_mid[c] = px;
    if (r >= 1) begin
      if (c >= 1) begin
        filt = {conv_channel(16), conv_channel(8), conv_channel(0)};
        expect_px((r == 1 || c == 1) ? win[4] : filt, c - 1, r - 1, 1'b0);
      end
      if (c == w - 1) expect_px(win[5], w - 1, r - 1, 1'b0);
    end
    // last row passes straight through
    if (r == h - 1) expect_px(px, c, r, c == w - 1);
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    px_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (expected_px.size() == 0) begin
        $error("unexpected result item at col %0d row %0d", res_bus.out_col, res_bus.out_row);
        fail_count++;
      end else begin
        want = expected_px.pop_front();
        if (res_bus.out_red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, res_bus.out_red);
          fail_count++;
        end
        if (res_bus.out_green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, res_bus.out_green);
          fail_count++;
        end
        if (res_bus.out_blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, res_bus.out_blue);
          fail_count++;
        end
        if (res_bus.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, res_bus.out_col);
          fail_count++;
        end
        if (res_bus.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, res_bus.out_row);
          fail_count++;
        end
        if (res_bus.frame_last !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, res_bus.frame_last);
          fail_count++;
        end
      end
    end
  end

  // entered and left at a falling edge; valid stays up for a following item
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (burst_left == 0) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.in_red <= r;
    pix_bus.in_green <= g;
    pix_bus.in_blue <= b;
    do @(posedge clk); while (!pix_bus.ready);
    track_pixel({r, g, b});
    pixels_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_pixel();
    send_pixel(rand_level(), rand_level(), rand_level());
  endtask

  task automatic send_to_frame_end();
    do send_random_pixel(); while (next_col != 0 || next_row != 0);
  endtask

  // stop the input, wait for every pending result and let the pipeline empty
  task automatic drain();
    pix_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_KERNEL: sel_kernel = val[2:0];
      CFG_WIDTH:  cfg_width = val[WCFG_W-1:0];
      CFG_HEIGHT: cfg_height = val[HCFG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [2:0] kern, input int unsigned w, input int unsigned h);
    drain();
    write_reg(CFG_KERNEL, CFG_DATA_W'(kern));
    write_reg(CFG_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    cfg_bus.valid <= 1'b0;
  endtask

  // saturating kernels on a single-window frame, then a zero-size frame
  task automatic test_edge_cases();
    configure(KERN_OUTLINE, 3, 3);
    for (int i = 0; i < 9; i++)
      send_pixel(i == 4 ? 8'hFF : 8'h00, i == 4 ? 8'h00 : 8'hFF, (i % 2) ? 8'hFF : 8'h00);
    configure(KERN_SHARPEN, 3, 3);
    for (int i = 0; i < 9; i++)
      send_pixel(i == 4 ? 8'h00 : 8'hFF, i == 4 ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF);
    // zero width and height act as one, unknown kernel is identity
    configure(KERN_UNKNOWN, 0, 0);
    send_pixel(8'hA5, 8'h5A, 8'hFF);
  endtask

  task automatic test_every_kernel();
    for (int k = 0; k < 8; k++) begin
      configure(3'(k), $urandom_range(3, 6), $urandom_range(3, 4));
      send_to_frame_end();
    end
  endtask

  task automatic test_size_limits();
    // width beyond the maximum acts as the maximum, single row passes through
    configure(KERN_BOX, 2047, 1);
    repeat (30) send_random_pixel();
    // the width then shrinks under the position
    configure(KERN_EMBOSS, 6, 3);
    send_to_frame_end();
    configure(KERN_OUTLINE, 3, MAX_HEIGHT);
    repeat (9) send_random_pixel();
    // height beyond the maximum keeps counting rows
    configure(KERN_GAUSS, 1, 8191);
    repeat (20) send_random_pixel();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned w;
    int unsigned h;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
      configure(3'($urandom_range(0, 7)), w, h);
      // a cut-off frame leaves the next size change landing mid-frame
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 20)) send_random_pixel();
      end else begin
        send_to_frame_end();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    pix_bus.valid = 1'b0;
    pix_bus.in_red = '0;
    pix_bus.in_green = '0;
    pix_bus.in_blue = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr = '0;
    cfg_bus.data = '0;
    reset_filter_state();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_edge_cases();
    test_every_kernel();
    test_size_limits();
    test_random_frames();
    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/c3k_pkg.sv
rtl/c3k_ifs.sv
rtl/c3k_line_mem.sv
rtl/c3k_filter.sv
rtl/c3k_emitter.sv
rtl/conv3x3_kernel_filter.sv
tb/conv3x3_kernel_filter_tb.sv
